@@ design/lmf_pkg.sv @@
`default_nettype none
package lmf_pkg;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_DRV,
      OP_GET_DRV,
      OP_MUL_FB,
      OP_GET_FB,
      OP_MUL_SQ,
      OP_GET_SQ,
      OP_DIV,
      OP_MUL_Y,
      OP_GET_Y,
      OP_MUL_STG,
      OP_GET_STG,
      OP_MUL_K3,
      OP_GET_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] stage_idx;
   } cmd_type;

   // Register indexes on the configuration port.
   localparam logic [7:0] REG_STAGE_GAIN    = 8'd0;
   localparam logic [7:0] REG_FEEDBACK_GAIN = 8'd1;
   localparam logic [7:0] REG_INPUT_DRIVE   = 8'd2;
   localparam logic [7:0] REG_FILTER_MODE   = 8'd3;

   // Output mode codes.
   localparam logic [2:0] MODE_LP24 = 3'd0;
   localparam logic [2:0] MODE_LP12 = 3'd1;
   localparam logic [2:0] MODE_HP24 = 3'd2;
   localparam logic [2:0] MODE_HP12 = 3'd3;
   localparam logic [2:0] MODE_BP   = 3'd4;

   localparam logic [15:0] DRIVE_RESET = 16'd4096;

endpackage
`default_nettype wire

@@ design/lmf_ctrl.sv @@
`default_nettype none
module lmf_ctrl #(
   parameter int DATA_WIDTH = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lmf_pkg::cmd_type      cmd
);

   localparam int F  = DATA_WIDTH - 4;
   localparam int CW = $clog2(F + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DRV_M, S_DRV_G, S_FB_M, S_FB_G, S_SQ_M, S_SQ_G, S_DIV,
      S_Y_M, S_Y_G, S_STG_M, S_STG_G, S_K3_M, S_OUT
   } state_type;

   state_type      state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           valid_ff, valid_in;
   logic           out_free;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   // Command decode from the current state.
   always_comb begin
      cmd.stage_idx = idx_ff;
      case (state_ff)
         S_IDLE:  cmd.op = req_valid ? lmf_pkg::OP_LOAD : lmf_pkg::OP_NOP;
         S_DRV_M: cmd.op = lmf_pkg::OP_MUL_DRV;
         S_DRV_G: cmd.op = lmf_pkg::OP_GET_DRV;
         S_FB_M:  cmd.op = lmf_pkg::OP_MUL_FB;
         S_FB_G:  cmd.op = lmf_pkg::OP_GET_FB;
         S_SQ_M:  cmd.op = lmf_pkg::OP_MUL_SQ;
         S_SQ_G:  cmd.op = lmf_pkg::OP_GET_SQ;
         S_DIV:   cmd.op = lmf_pkg::OP_DIV;
         S_Y_M:   cmd.op = lmf_pkg::OP_MUL_Y;
         S_Y_G:   cmd.op = lmf_pkg::OP_GET_Y;
         S_STG_M: cmd.op = lmf_pkg::OP_MUL_STG;
         S_STG_G: cmd.op = lmf_pkg::OP_GET_STG;
         S_K3_M:  cmd.op = lmf_pkg::OP_MUL_K3;
         S_OUT:   cmd.op = out_free ? lmf_pkg::OP_GET_OUT : lmf_pkg::OP_NOP;
         default: cmd.op = lmf_pkg::OP_NOP;
      endcase
   end

   // Next state, stage index, divider count and output valid.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_DRV_M;
         S_DRV_M: state_in = S_DRV_G;
         S_DRV_G: state_in = S_FB_M;
         S_FB_M:  state_in = S_FB_G;
         S_FB_G:  state_in = S_SQ_M;
         S_SQ_M:  state_in = S_SQ_G;
         S_SQ_G: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            if (cnt_ff == CW'(F)) begin
               state_in = S_Y_M;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_Y_M:   state_in = S_Y_G;
         S_Y_G: begin
            state_in = S_STG_M;
            idx_in   = 2'd0;
         end
         S_STG_M: state_in = S_STG_G;
         S_STG_G: begin
            if (idx_ff == 2'd3) begin
               state_in = S_K3_M;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_STG_M;
            end
         end
         S_K3_M:  state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

@@ design/lmf_datapath.sv @@
`default_nettype none
module lmf_datapath #(
   parameter int DATA_WIDTH = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lmf_pkg::cmd_type             cmd,
   input  wire logic signed [DATA_WIDTH-1:0] req_sample_in,
   input  wire logic                         csr_valid,
   input  wire logic [7:0]                   csr_index,
   input  wire logic [31:0]                  csr_wdata,
   output logic signed [DATA_WIDTH-1:0]      rsp_sample_out
);

   localparam int W   = DATA_WIDTH;
   localparam int F   = W - 4;
   localparam int PW  = W + 4;
   localparam int PRW = 2 * PW;
   localparam int DW  = W + 6;
   localparam logic signed [PRW-1:0] SMAX = PRW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [PRW-1:0] SMIN = -SMAX - PRW'(1);
   localparam logic [PRW-1:0] HALF  = PRW'(64'd1 << (F - 1));
   localparam logic [PRW-1:0] BASE  = PRW'(64'd27 << F);

   logic [15:0]             gain_ff;
   logic [18:0]             fbk_ff;
   logic [15:0]             drive_ff;
   logic [2:0]              mode_ff;
   logic signed [W-1:0]     smp_ff, inp_ff, out_ff;
   logic signed [W-1:0]     stage_ff [4];
   logic [W-1:0]            abs_ff;
   logic                    neg_ff;
   logic signed [PW-1:0]    drv_ff;
   logic [DW-1:0]           den_ff;
   logic [DW:0]             rem_ff;
   logic [F:0]              quo_ff;
   logic signed [PRW-1:0]   prod_ff;

   logic signed [PW-1:0]    op_a, op_b;
   logic signed [W-1:0]     prev;
   logic signed [W:0]       diff;

   function automatic logic signed [PRW-1:0] rnd16(input logic signed [PRW-1:0] v);
      return (v + PRW'(32768)) >>> 16;
   endfunction

   function automatic logic signed [PRW-1:0] sat(input logic signed [PRW-1:0] v);
      logic signed [PRW-1:0] r;
      r = v;
      if (v > SMAX) r = SMAX;
      if (v < SMIN) r = SMIN;
      return r;
   endfunction

   assign rsp_sample_out = out_ff;

   // Stage input and difference for the one-pole update.
   assign prev = (cmd.stage_idx == 2'd0) ? inp_ff : stage_ff[cmd.stage_idx - 2'd1];
   assign diff = (W + 1)'(prev) - (W + 1)'(stage_ff[cmd.stage_idx]);

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = PW'(smp_ff);
      op_b = $signed({{(PW - 16){1'b0}}, drive_ff});
      case (cmd.op)
         lmf_pkg::OP_MUL_FB, lmf_pkg::OP_MUL_K3: begin
            op_a = PW'(stage_ff[3]);
            op_b = $signed({{(PW - 19){1'b0}}, fbk_ff});
         end
         lmf_pkg::OP_MUL_SQ: begin
            op_a = $signed({{(PW - W){1'b0}}, abs_ff});
            op_b = $signed({{(PW - W){1'b0}}, abs_ff});
         end
         lmf_pkg::OP_MUL_Y: begin
            op_a = $signed({{(PW - W){1'b0}}, abs_ff});
            op_b = $signed({{(PW - F - 1){1'b0}}, quo_ff});
         end
         lmf_pkg::OP_MUL_STG: begin
            op_a = PW'(diff);
            op_b = $signed({{(PW - 16){1'b0}}, gain_ff});
         end
         default: begin
            op_a = PW'(smp_ff);
            op_b = $signed({{(PW - 16){1'b0}}, drive_ff});
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         fbk_ff   <= '0;
         drive_ff <= lmf_pkg::DRIVE_RESET;
         mode_ff  <= lmf_pkg::MODE_LP24;
      end else if (csr_valid) begin
         case (csr_index)
            lmf_pkg::REG_STAGE_GAIN:    gain_ff  <= csr_wdata[15:0];
            lmf_pkg::REG_FEEDBACK_GAIN: fbk_ff   <= csr_wdata[18:0];
            lmf_pkg::REG_INPUT_DRIVE:   drive_ff <= csr_wdata[15:0];
            lmf_pkg::REG_FILTER_MODE:   mode_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Filter state, cleared at reset.
   always_ff @(posedge clock) begin
      logic signed [PRW-1:0] sv;
      sv = PRW'(stage_ff[cmd.stage_idx]) + (rnd16(prod_ff) <<< 1);
      if (reset) begin
         for (int i = 0; i < 4; i++) stage_ff[i] <= '0;
      end else if (cmd.op == lmf_pkg::OP_GET_STG) begin
         stage_ff[cmd.stage_idx] <= W'(sat(sv));
      end
   end

   // Working registers of the sample computation.
   always_ff @(posedge clock) begin
      logic signed [PRW-1:0] t, xs, k3, res;
      logic signed [W-1:0]   xw;
      logic [PRW-1:0]        qv, yv;
      logic [W:0]            y;
      t   = (PRW'(drv_ff) - rnd16(prod_ff)) >>> 2;
      xs  = sat(t);
      xw  = W'(xs);
      qv  = ($unsigned(prod_ff) + HALF) >> F;
      yv  = ($unsigned(prod_ff) + HALF) >> F;
      y   = (W + 1)'(yv);
      k3  = rnd16(prod_ff);
      case (mode_ff)
         lmf_pkg::MODE_LP12: res = PRW'(stage_ff[1]);
         lmf_pkg::MODE_HP24: res = PRW'(inp_ff) - k3 - 4 * PRW'(stage_ff[0])
                                   + 6 * PRW'(stage_ff[1]) - 4 * PRW'(stage_ff[2])
                                   + PRW'(stage_ff[3]);
         lmf_pkg::MODE_HP12: res = PRW'(inp_ff) - PRW'(stage_ff[0]) - PRW'(stage_ff[1]);
         lmf_pkg::MODE_BP:   res = 4 * (PRW'(stage_ff[1]) - 2 * PRW'(stage_ff[2])
                                   + PRW'(stage_ff[3]));
         default:            res = PRW'(stage_ff[3]);
      endcase
      case (cmd.op)
         lmf_pkg::OP_LOAD: smp_ff <= req_sample_in;
         lmf_pkg::OP_MUL_DRV, lmf_pkg::OP_MUL_FB, lmf_pkg::OP_MUL_SQ,
         lmf_pkg::OP_MUL_Y, lmf_pkg::OP_MUL_STG, lmf_pkg::OP_MUL_K3: begin
            prod_ff <= PRW'(op_a) * PRW'(op_b);
         end
         lmf_pkg::OP_GET_DRV: drv_ff <= PW'((prod_ff + PRW'(2048)) >>> 12);
         lmf_pkg::OP_GET_FB: begin
            neg_ff <= xw[W-1];
            abs_ff <= xw[W-1] ? W'(-xw) : W'(xw);
         end
         lmf_pkg::OP_GET_SQ: begin
            rem_ff <= (DW + 1)'(BASE + qv);
            den_ff <= DW'(BASE + 9 * qv);
            quo_ff <= '0;
         end
         lmf_pkg::OP_DIV: begin
            // One restoring quotient bit per cycle.
            if (rem_ff >= {1'b0, den_ff}) begin
               rem_ff <= (DW + 1)'((rem_ff - {1'b0, den_ff}) << 1);
               quo_ff <= {quo_ff[F-1:0], 1'b1};
            end else begin
               rem_ff <= (DW + 1)'(rem_ff << 1);
               quo_ff <= {quo_ff[F-1:0], 1'b0};
            end
         end
         lmf_pkg::OP_GET_Y: inp_ff <= neg_ff ? W'(-y) : W'(y);
         lmf_pkg::OP_GET_OUT: out_ff <= W'(sat(res));
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ design/ladder_multimode_filter.sv @@
`default_nettype none
// Four-pole ladder filter with selectable LP24, LP12, HP24, HP12 and bandpass
// outputs on signed Q3.20 samples (DATA_WIDTH bits, four integer bits).
// Each sample runs through the controller's states in order: one shared
// multiplier is used nine times, each product registered and then taken by
// a separate step except the last feedback product, which goes straight to
// the output stage, and the tanh saturator's division runs one quotient bit
// per cycle for DATA_WIDTH - 3 quotient bits. A new sample is taken once the
// previous one has left the datapath; its result then waits in the output
// register. Registers are to be written on the csr port only while the block
// is idle, which the block itself does not enforce: 0 stage gain, 1 feedback
// gain, 2 input drive, 3 filter mode; other indexes are ignored.
module ladder_multimode_filter #(
   parameter int DATA_WIDTH = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_sample_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_sample_out,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [7:0]                   csr_index,
   input  wire logic [31:0]                  csr_wdata
);

   lmf_pkg::cmd_type cmd;

   // Registers accept a transaction in any cycle.
   assign csr_ready = 1'b1;

   lmf_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lmf_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
`default_nettype wire
